// ----- hw/rtl/scp_pkg.sv -----
`timescale 1ns / 1ps

package scp_pkg;

  // Field formats
  localparam int ANGLE_W         = 32;
  localparam int VALUE_W         = 32;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 30;

  // Range reduction runs in Q.32
  localparam int ASH = 32 - ANGLE_FRAC_BITS;   // angle to Q.32 shift
  localparam int XW  = ANGLE_W + ASH + 1;      // widened angle, signed
  localparam int MW  = XW - 1;                 // biased magnitude, unsigned
  localparam int HW  = MW - 32;                // whole-radian index bits
  localparam int KT_N = 1 << HW;               // quotient table depth
  localparam int TW  = 35;                     // bits of 2*pi in Q.32
  localparam int RMW = TW + 1;                 // remainder, below 2 * (2*pi)
  localparam int DW  = TW;                     // reduced angle, signed
  localparam int CW  = DW + 1;                 // fold candidates, signed

  // Polynomial runs in Q.30
  localparam int RW    = 33;
  localparam int Q_FRAC = 30;

  localparam longint PI_Q32      = 64'sh3243F6A89;
  localparam longint TWO_PI_Q32  = 64'sh6487ED511;
  localparam longint HALF_PI_Q32 = 64'sh1921FB544;
  // (2*pi - 1) / 2: rounding bias for the turn count
  localparam longint HALF_T_Q32  = (TWO_PI_Q32 - 1) / 2;

  localparam longint Q30_ONE = 64'sd1 <<< Q_FRAC;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [XW-1:0]      x_t;
  typedef logic        [MW-1:0]      mp_t;
  typedef logic        [RMW-1:0]     rm_t;
  typedef logic signed [DW-1:0]      d_t;
  typedef logic signed [RW-1:0]      r_t;

  // Taylor coefficients, rounded to nearest in Q.30
  localparam r_t C_ONE = RW'(Q30_ONE);
  localparam r_t C3    = RW'((Q30_ONE + 3) / 6);
  localparam r_t C5    = RW'((Q30_ONE + 60) / 120);
  localparam r_t C7    = RW'((Q30_ONE + 2520) / 5040);
  localparam r_t C9    = RW'((Q30_ONE + 181440) / 362880);

  // Whole-turn estimate times 2*pi, indexed by the integer radians of the
  // biased magnitude. The true count is this entry's count or one more.
  typedef mp_t kt_tbl_t [KT_N];

  function automatic kt_tbl_t make_kt_tbl();
    kt_tbl_t t;
    for (int i = 0; i < KT_N; i++) begin
      t[i] = MW'(((longint'(i) <<< 32) / TWO_PI_Q32) * TWO_PI_Q32);
    end
    return t;
  endfunction

  localparam kt_tbl_t KT_TBL = make_kt_tbl();

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

endpackage

// ----- hw/rtl/scp_in_if.sv -----
`timescale 1ns / 1ps

interface scp_in_if;
  import scp_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  angle_t angle;

  modport source (output valid, output kind, output angle, input ready);
  modport sink   (input valid, input kind, input angle, output ready);
endinterface

// ----- hw/rtl/scp_out_if.sv -----
`timescale 1ns / 1ps

interface scp_out_if;
  import scp_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/scp_front.sv -----
`timescale 1ns / 1ps

module scp_front (
  input  logic          clk,
  input  logic          rst_n,
  scp_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output scp_pkg::r_t   push_data
);
  import scp_pkg::*;

  localparam rm_t TP_RM = RMW'(TWO_PI_Q32);
  localparam x_t  HP_X  = XW'(HALF_PI_Q32);
  localparam x_t  HT_X  = XW'(HALF_T_Q32);
  localparam logic signed [RMW:0] HT_S  = (RMW+1)'(HALF_T_Q32);
  localparam logic signed [RMW:0] THT_S = (RMW+1)'(TWO_PI_Q32 + HALF_T_Q32);
  localparam d_t HP_D = DW'(HALF_PI_Q32);
  localparam d_t HN_D = DW'(-HALF_PI_Q32);
  localparam logic signed [CW-1:0] FOLD_HI = CW'(PI_Q32 + 2);
  localparam logic signed [CW-1:0] FOLD_LO = CW'(-PI_Q32 + 2);

  logic [4:0] fv_r, fv_nxt;
  logic       adv;

  x_t  f1_x_r;
  mp_t f2_mp_r;
  logic f2_neg_r, f3_neg_r, f4_neg_unused;
  rm_t f3_rm_r;
  d_t  f4_xr_r;
  r_t  f5_r_r;

  x_t  f1_x_nxt;
  mp_t f2_mp_nxt;
  rm_t f3_rm_nxt;
  d_t  f4_xr_nxt;
  r_t  f5_r_nxt;

  logic signed [RMW:0]  rm_s;
  logic                 rm_ge;
  logic signed [CW-1:0] cand0, cand1, cand2, cand;

  // whole front moves unless the last stage is blocked by a full queue
  assign adv         = !(fv_r[4] && q_full);
  assign in_ch.ready = adv;
  assign push        = fv_r[4] && !q_full;
  assign push_data   = f5_r_r;
  assign fv_nxt      = {fv_r[3:0], in_ch.valid};
  assign f4_neg_unused = 1'b0;

  // F1: widen to Q.32, cosine adds a quarter turn
  always_comb begin
    f1_x_nxt = (XW'(in_ch.angle) <<< ASH) + (in_ch.kind ? HP_X : '0);
  end

  // F2: magnitude plus rounding bias, one adder either way
  always_comb begin
    if (f1_x_r[XW-1]) begin
      f2_mp_nxt = MW'(HT_X - f1_x_r);
    end else begin
      f2_mp_nxt = MW'(f1_x_r + HT_X);
    end
  end

  // F3: take off the estimated whole turns
  always_comb begin
    f3_rm_nxt = RMW'(f2_mp_r - KT_TBL[f2_mp_r[MW-1:32]]);
  end

  // F4: one more turn if the estimate fell short, drop bias, restore sign
  always_comb begin
    rm_s  = signed'({1'b0, f3_rm_r});
    rm_ge = f3_rm_r >= TP_RM;
    priority if (rm_ge && f3_neg_r) begin
      f4_xr_nxt = DW'(THT_S - rm_s);
    end else if (rm_ge) begin
      f4_xr_nxt = DW'(rm_s - THT_S);
    end else if (f3_neg_r) begin
      f4_xr_nxt = DW'(HT_S - rm_s);
    end else begin
      f4_xr_nxt = DW'(rm_s - HT_S);
    end
  end

  // F5: fold about +-pi/2, with the Q.30 rounding bias folded into each path
  always_comb begin
    cand0 = CW'(f4_xr_r) + CW'(2);
    cand1 = FOLD_HI - CW'(f4_xr_r);
    cand2 = FOLD_LO - CW'(f4_xr_r);
    priority if (f4_xr_r > HP_D) begin
      cand = cand1;
    end else if (f4_xr_r < HN_D) begin
      cand = cand2;
    end else begin
      cand = cand0;
    end
    f5_r_nxt = cand[RW+1:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_x_r   <= f1_x_nxt;
      f2_mp_r  <= f2_mp_nxt;
      f2_neg_r <= f1_x_r[XW-1];
      f3_rm_r  <= f3_rm_nxt;
      f3_neg_r <= f2_neg_r | f4_neg_unused;
      f4_xr_r  <= f4_xr_nxt;
      f5_r_r   <= f5_r_nxt;
    end
  end

endmodule

// ----- hw/rtl/scp_queue.sv -----
`timescale 1ns / 1ps

module scp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scp_pkg::r_t      push_data,
  input  logic             pop,
  output scp_pkg::r_t      pop_data,
  output scp_pkg::q_stat_t stat
);
  import scp_pkg::*;

  r_t             mem_r [QD];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.full  = cnt_r == (QAW+1)'(QD);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/scp_back.sv -----
`timescale 1ns / 1ps

module scp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  scp_pkg::q_stat_t q_stat,
  input  scp_pkg::r_t      q_data,
  output logic             pop,
  scp_out_if.source        out_ch
);
  import scp_pkg::*;

  localparam int PW2    = 2 * RW;
  localparam int SH_OUT = Q_FRAC - OUT_FRAC_BITS;
  localparam logic signed [PW2-1:0] Q_RND = PW2'(64'sd1 <<< (Q_FRAC - 1));
  localparam r_t OUT_RND = RW'((64'sd1 <<< SH_OUT) >>> 1);
  localparam r_t LIM_P   = RW'(64'sd1 <<< OUT_FRAC_BITS);
  localparam r_t LIM_N   = RW'(-(64'sd1 <<< OUT_FRAC_BITS));

  // Q.30 product, round half up
  function automatic r_t qmul(input r_t a, input r_t b);
    logic signed [PW2-1:0] prod;
    prod = PW2'(a) * PW2'(b) + Q_RND;
    return prod[RW+Q_FRAC-1:Q_FRAC];
  endfunction

  logic [6:0] bv_r, bv_nxt;
  logic       adv;

  r_t b1_r_r, b2_r_r, b3_r_r, b4_r_r, b5_r_r;
  r_t b1_r2_r, b2_r2_r, b3_r2_r, b4_r2_r;
  r_t b2_p_r, b3_p_r, b4_p_r, b5_p_r;
  r_t b6_y_r;
  value_t b7_val_r, b7_val_nxt;
  r_t y_rnd;

  // back advances whenever the output word is free or being taken
  assign adv          = !bv_r[6] || out_ch.ready;
  assign pop          = adv && !q_stat.empty;
  assign bv_nxt       = {bv_r[5:0], !q_stat.empty};
  assign out_ch.valid = bv_r[6];
  assign out_ch.value = b7_val_r;

  // output rounding and clamp to +-1.0
  always_comb begin
    y_rnd = (b6_y_r + OUT_RND) >>> SH_OUT;
    priority if (y_rnd > LIM_P) begin
      b7_val_nxt = VALUE_W'(LIM_P);
    end else if (y_rnd < LIM_N) begin
      b7_val_nxt = VALUE_W'(LIM_N);
    end else begin
      b7_val_nxt = VALUE_W'(y_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (adv) begin
      bv_r <= bv_nxt;
    end
  end

  // Horner chain, one multiply per stage through b6; b7 takes the rounded, clamped word
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r_r   <= q_data;
      b1_r2_r  <= qmul(q_data, q_data);
      b2_r_r   <= b1_r_r;
      b2_r2_r  <= b1_r2_r;
      b2_p_r   <= qmul(b1_r2_r, C9) - C7;
      b3_r_r   <= b2_r_r;
      b3_r2_r  <= b2_r2_r;
      b3_p_r   <= qmul(b2_r2_r, b2_p_r) + C5;
      b4_r_r   <= b3_r_r;
      b4_r2_r  <= b3_r2_r;
      b4_p_r   <= qmul(b3_r2_r, b3_p_r) - C3;
      b5_r_r   <= b4_r_r;
      b5_p_r   <= qmul(b4_r2_r, b4_p_r) + C_ONE;
      b6_y_r   <= qmul(b5_r_r, b5_p_r);
      b7_val_r <= b7_val_nxt;
    end
  end

endmodule

// ----- hw/rtl/sine_cosine_polynomial.sv -----
`timescale 1ns / 1ps

// Fixed-point sine/cosine. Each input word carries a Q8.24 angle in radians
// and a kind bit (0 sine, 1 cosine); each output word is the Q2.30 result,
// clamped to +-1.0. Cosine adds a quarter turn, whole turns are removed
// exactly (nearest count, ties away from zero), the angle is folded into
// [-pi/2, pi/2] and sine is the Taylor series through x^9 in Horner form.
// The block takes one word per clock while input ready is high and has no
// state between words. The word passes 13 registers: a 5-stage
// range-reduction front end, one through a 4-entry queue, and a 7-stage
// back end (six stages with one 33x33 multiply each, then round and
// clamp). The queue lets the front keep accepting for a few words while the
// output stalls; input ready drops only once the queue is full and the
// front's last stage holds a word.
module sine_cosine_polynomial (
  input  logic      clk,
  input  logic      rst_n,
  scp_in_if.sink    in_ch,
  scp_out_if.source out_ch
);
  import scp_pkg::*;

  logic    push, pop;
  r_t      push_data, pop_data;
  q_stat_t q_stat;

  scp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_stat.full),
    .push      (push),
    .push_data (push_data)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  scp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (pop_data),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/scp_checker.sv -----
`timescale 1ns / 1ps

module scp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input scp_pkg::value_t out_value
);
  import scp_pkg::*;

  localparam value_t LIM_P = VALUE_W'(64'sd1 <<< OUT_FRAC_BITS);
  localparam value_t LIM_N = VALUE_W'(-(64'sd1 <<< OUT_FRAC_BITS));

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("output word changed while stalled");

  // result never leaves +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= LIM_P) && (out_value >= LIM_N))
    else $error("output word outside +-1.0");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input only backs up when the output was stalled the cycle before
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

endmodule

bind sine_cosine_polynomial scp_checker u_scp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import scp_pkg::angle_t;
  import scp_pkg::value_t;

  // Fixed-point constants for the expected-value calculation
  localparam int     ANGLE_SH   = 32 - scp_pkg::ANGLE_FRAC_BITS;
  localparam int     OUT_SH     = 30 - scp_pkg::OUT_FRAC_BITS;
  localparam longint PI_FX      = 64'sh3243F6A89;
  localparam longint TWO_PI_FX  = 64'sh6487ED511;
  localparam longint HALF_PI_FX = 64'sh1921FB544;
  localparam longint ONE_Q30    = 64'sd1 <<< 30;
  localparam longint TAY_C3     = (ONE_Q30 + 3) / 6;
  localparam longint TAY_C5     = (ONE_Q30 + 60) / 120;
  localparam longint TAY_C7     = (ONE_Q30 + 2520) / 5040;
  localparam longint TAY_C9     = (ONE_Q30 + 181440) / 362880;

  // Angle landmarks in the input format (Q8.24)
  localparam int ANG_QUARTER = 26353589;
  localparam int ANG_HALF    = 52707179;
  localparam int ANG_TURN    = 105414357;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 610;

  logic clk;
  logic rst_n;

  scp_in_if  in_ch();
  scp_out_if out_ch();

  sine_cosine_polynomial DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  value_t expected_values[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q.30 product, round half up
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Expected sine/cosine for one input word
  function automatic value_t predict_sincos(input logic want_cos, input angle_t ang);
    longint           x;
    longint           step;
    longint           r;
    longint           r2;
    longint           p;
    longint           y;
    longint           lim;
    longint unsigned  mag;
    longint unsigned  turns;
    logic             neg;
    x = longint'(ang) <<< ANGLE_SH;
    if (want_cos) x = x + HALF_PI_FX;
    // remove whole turns, count rounded half away from zero
    neg   = (x < 0);
    mag   = neg ? longint'(-x) : x;
    turns = (2 * mag + longint'(TWO_PI_FX)) / (2 * longint'(TWO_PI_FX));
    step  = longint'(turns) * TWO_PI_FX;
    x     = neg ? x + step : x - step;
    // fold into [-pi/2, pi/2]
    if (x > HALF_PI_FX)  x = PI_FX - x;
    if (x < -HALF_PI_FX) x = -PI_FX - x;
    // Horner evaluation in Q.30
    r  = (x + 2) >>> 2;
    r2 = mul_q30(r, r);
    p  = TAY_C9;
    p  = mul_q30(r2, p) - TAY_C7;
    p  = mul_q30(r2, p) + TAY_C5;
    p  = mul_q30(r2, p) - TAY_C3;
    p  = mul_q30(r2, p) + ONE_Q30;
    y  = mul_q30(r, p);
    if (OUT_SH > 0) y = (y + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
    lim = 64'sd1 <<< scp_pkg::OUT_FRAC_BITS;
    if (y > lim)  y = lim;
    if (y < -lim) y = -lim;
    return value_t'(y);
  endfunction

  // Send one word; entered and left at a falling edge
  task automatic send_word(input logic want_cos, input angle_t ang);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= want_cos;
    in_ch.angle <= ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_values.push_back(predict_sincos(want_cos, ang));
    @(negedge clk);
  endtask

  // Zero, full-scale and one-LSB angles, both kinds, and one full turn
  task automatic test_extremes();
    send_word(1'b0, 32'sd0);
    send_word(1'b1, 32'sd0);
    send_word(1'b0, 32'sh7FFFFFFF);
    send_word(1'b1, 32'sh7FFFFFFF);
    send_word(1'b0, 32'sh80000000);
    send_word(1'b1, 32'sh80000000);
    send_word(1'b0, 32'sd1);
    send_word(1'b1, -32'sd1);
    send_word(1'b0, -32'sd1);
    send_word(1'b0, ANG_TURN);
  endtask

  // Angles around plus and minus half a turn and one and a half turns, where the turn count flips
  task automatic test_half_turn();
    send_word(1'b0, ANG_HALF);
    send_word(1'b0, ANG_HALF - 1);
    send_word(1'b0, -ANG_HALF);
    send_word(1'b1, ANG_HALF);
    send_word(1'b1, -ANG_HALF);
    send_word(1'b0, 3 * ANG_HALF);
  endtask

  // Around a quarter turn: fold edge and overshoot into saturation
  task automatic test_quarter_turn();
    send_word(1'b0, ANG_QUARTER);
    send_word(1'b0, ANG_QUARTER - 1);
    send_word(1'b0, -ANG_QUARTER);
    send_word(1'b1, -ANG_QUARTER);
    send_word(1'b0, ANG_QUARTER + 1);
    send_word(1'b1, ANG_QUARTER);
  endtask

  // Random words: full range, a few turns around zero, near quarter turns
  task automatic test_random(input int count);
    longint ang;
    logic   want_cos;
    for (int i = 0; i < count; i++) begin
      want_cos = 1'($urandom_range(1));
      case ($urandom_range(2))
        0: ang = longint'(angle_t'($urandom));
        1: ang = longint'($urandom_range(4 * ANG_TURN)) - 2 * ANG_TURN;
        default: begin
          ang = (longint'($urandom_range(160)) - 80) * ANG_QUARTER
                + longint'($urandom_range(16)) - 8;
        end
      endcase
      send_word(want_cos, angle_t'(ang));
    end
  endtask

  // Output side: random back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin
    value_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_values.size() == 0) begin
        $error("value: unexpected word %0d", out_ch.value);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (out_ch.value !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, out_ch.value);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = 1'b0;
    in_ch.angle  = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles less than receiver
    src_idle_pct = 21;
    snk_idle_pct = 47;
    test_extremes();
    test_half_turn();
    test_quarter_turn();
    test_random(RANDOM_WORDS);

    // receiver idles less than sender
    src_idle_pct = 47;
    snk_idle_pct = 21;
    test_random(RANDOM_WORDS);

    // full rate
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(RANDOM_WORDS);
    in_ch.valid <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/scp_pkg.sv
hw/rtl/scp_in_if.sv
hw/rtl/scp_out_if.sv
hw/rtl/scp_front.sv
hw/rtl/scp_queue.sv
hw/rtl/scp_back.sv
hw/rtl/sine_cosine_polynomial.sv
hw/rtl/scp_checker.sv
bench/tb_top.sv
